// ----- rtl/core/dsfp_pkg.sv -----
// Shared types and byte codes for the DER signature to fixed pair converter.
// Used by the parser, the drain and the top level in rtl/core; depends on nothing.
package dsfp_pkg;

  // DER tags and fixed thresholds of the parser.
  localparam logic [7:0] SEQ_TAG   = 8'h30;
  localparam logic [7:0] INT_TAG   = 8'h02;
  localparam logic [7:0] LEAD_ZERO = 8'h00;
  localparam int unsigned MIN_TOTAL   = 8;
  localparam int unsigned MIN_ALIGNED = 4;

  // Status codes of a result item.
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

  // Parser to bank control.
  typedef struct packed {
    logic wr_en;     // store the current byte at the parser's slot
    logic sig_done;  // the end-marked byte was taken
    logic sig_bad;   // the finished signature is malformed
  } parse_evt_t;

  // Drain to bank control.
  typedef struct packed {
    logic release_bank;  // the bank named below has been fully read out
    logic bank;
  } drain_evt_t;

endpackage

// ----- rtl/core/dsfp_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Stand-alone; no package needed.
module dsfp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/core/dsfp_parser.sv -----
// DER byte parser: tracks the SEQUENCE and INTEGER fields, picks store slots for R and S.
// Depends on dsfp_pkg.
module dsfp_parser #(
  parameter int unsigned COMPONENT_BYTES = 32,
  parameter int unsigned MAX_INPUT_BYTES = 256,
  localparam int unsigned STORE = 2 * COMPONENT_BYTES,
  localparam int unsigned SW    = $clog2(STORE)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  take,
  input  logic [7:0]            der_byte,
  input  logic                  end_of_buffer,
  output logic [SW-1:0]         wr_slot,
  output dsfp_pkg::parse_evt_t  evt
);

  localparam int unsigned CW = $clog2(MAX_INPUT_BYTES + 2);
  localparam int unsigned EW = ((CW > 8) ? CW : 8) + 1;
  localparam logic [CW-1:0] CNT_MAX  = CW'(MAX_INPUT_BYTES + 1);
  localparam logic [7:0]    COMP     = 8'(COMPONENT_BYTES);
  localparam logic [7:0]    LONG_LEN = 8'(COMPONENT_BYTES + 1);

  typedef enum logic [10:0] {
    PH_SEEK   = 11'b000_0000_0001,
    PH_SEQLEN = 11'b000_0000_0010,
    PH_RTAG   = 11'b000_0000_0100,
    PH_RLEN   = 11'b000_0000_1000,
    PH_RLEAD  = 11'b000_0001_0000,
    PH_RBODY  = 11'b000_0010_0000,
    PH_STAG   = 11'b000_0100_0000,
    PH_SLEN   = 11'b000_1000_0000,
    PH_SLEAD  = 11'b001_0000_0000,
    PH_SBODY  = 11'b010_0000_0000,
    PH_DONE   = 11'b100_0000_0000
  } phase_t;

  phase_t        phase, phase_next;
  logic [CW-1:0] total, total_next;
  logic [CW-1:0] aligned, aligned_next;
  logic [7:0]    seq_len, seq_len_next;
  logic [7:0]    left, left_next;
  logic [SW-1:0] slot, slot_next;
  logic          err, err_next;
  logic          wr;
  logic          is_s;
  logic [7:0]    base;
  logic [7:0]    left_dec;
  logic          bad;

  always_comb begin
    phase_next   = phase;
    seq_len_next = seq_len;
    left_next    = left;
    slot_next    = slot;
    err_next     = err;
    wr           = 1'b0;
    is_s         = (phase == PH_SLEN) || (phase == PH_SBODY);
    base         = is_s ? COMP : 8'd0;
    left_dec     = (left != 8'd0) ? left - 8'd1 : left;
    total_next   = (total < CNT_MAX) ? total + CW'(1) : total;
    aligned_next = aligned;
    if ((phase != PH_SEEK) || (der_byte == dsfp_pkg::SEQ_TAG)) begin
      aligned_next = (aligned < CNT_MAX) ? aligned + CW'(1) : aligned;
    end
    if (!err) begin
      case (phase)
        PH_SEEK: begin
          if (der_byte == dsfp_pkg::SEQ_TAG) phase_next = PH_SEQLEN;
        end
        PH_SEQLEN: begin
          seq_len_next = der_byte;
          phase_next   = PH_RTAG;
        end
        PH_RTAG, PH_STAG: begin
          if (der_byte != dsfp_pkg::INT_TAG) err_next = 1'b1;
          else phase_next = (phase == PH_RTAG) ? PH_RLEN : PH_SLEN;
        end
        PH_RLEN, PH_SLEN: begin
          if (der_byte > LONG_LEN) begin
            err_next = 1'b1;
          end else if (der_byte == LONG_LEN) begin
            left_next  = COMP;
            slot_next  = SW'(base);
            phase_next = is_s ? PH_SLEAD : PH_RLEAD;
          end else if (der_byte == 8'd0) begin
            phase_next = is_s ? PH_DONE : PH_STAG;
          end else begin
            left_next  = der_byte;
            slot_next  = SW'(base + COMP - der_byte);
            phase_next = is_s ? PH_SBODY : PH_RBODY;
          end
        end
        PH_RLEAD, PH_SLEAD: begin
          if (der_byte != dsfp_pkg::LEAD_ZERO) err_next = 1'b1;
          else phase_next = (phase == PH_RLEAD) ? PH_RBODY : PH_SBODY;
        end
        PH_RBODY, PH_SBODY: begin
          wr        = ({1'b0, slot} < (SW + 1)'(STORE));
          slot_next = slot + SW'(1);
          left_next = left_dec;
          if (left_dec == 8'd0) phase_next = is_s ? PH_DONE : PH_STAG;
        end
        default: begin
        end
      endcase
    end
    bad = err_next
       || (total_next < CW'(dsfp_pkg::MIN_TOTAL))
       || (phase_next != PH_DONE)
       || (aligned_next < CW'(dsfp_pkg::MIN_ALIGNED))
       || ((EW'(seq_len_next) + EW'(2)) > EW'(aligned_next));
  end

  assign wr_slot      = slot;
  assign evt.wr_en    = take & wr;
  assign evt.sig_done = take & end_of_buffer;
  assign evt.sig_bad  = bad;

  // The end-marked item hands the signature off and starts the next one clean.
  always_ff @(posedge clk) begin
    if (rst || (take && end_of_buffer)) begin
      phase   <= PH_SEEK;
      total   <= '0;
      aligned <= '0;
      seq_len <= '0;
      left    <= '0;
      slot    <= '0;
      err     <= 1'b0;
    end else if (take) begin
      phase   <= phase_next;
      total   <= total_next;
      aligned <= aligned_next;
      seq_len <= seq_len_next;
      left    <= left_next;
      slot    <= slot_next;
      err     <= err_next;
    end
  end

endmodule

// ----- rtl/core/dsfp_drain.sv -----
// Read-out of finished banks: RAM read issue stage and the output register.
// Depends on dsfp_pkg; reads the store through the top level's RAM instance.
module dsfp_drain #(
  parameter int unsigned COMPONENT_BYTES = 32,
  localparam int unsigned STORE = 2 * COMPONENT_BYTES,
  localparam int unsigned SW    = $clog2(STORE)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [1:0]            full,
  input  logic [1:0]            bad,
  output logic                  rd_en,
  output logic                  rd_bank,
  output logic [SW-1:0]         rd_slot,
  input  logic                  entry_valid,
  input  logic [7:0]            rd_data,
  output dsfp_pkg::drain_evt_t  evt,
  output logic                  sig_valid,
  input  logic                  sig_ready,
  output logic [7:0]            sig_byte,
  output logic [5:0]            byte_index,
  output logic                  status,
  output logic                  last_of_run
);

  localparam logic [SW-1:0] LAST_SLOT = SW'(STORE - 1);

  logic          db;
  logic [SW-1:0] k;
  logic          s1_valid;
  logic          s1_err;
  logic          s1_vld;
  logic [5:0]    s1_idx;
  logic          s1_last;
  logic          s2_load;
  logic          issue;
  logic          k_last;

  assign s2_load = s1_valid && (!sig_valid || sig_ready);
  assign issue   = full[db] && (!s1_valid || s2_load);
  assign k_last  = (k == LAST_SLOT);

  assign rd_en   = issue && !bad[db];
  assign rd_bank = db;
  assign rd_slot = k;

  assign evt.release_bank = issue && (bad[db] || k_last);
  assign evt.bank         = db;

  always_ff @(posedge clk) begin
    if (rst) begin
      db       <= 1'b0;
      k        <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (issue) begin
        s1_valid <= 1'b1;
        s1_err   <= bad[db];
        s1_vld   <= entry_valid;
        s1_idx   <= bad[db] ? 6'd0 : 6'(k);
        s1_last  <= bad[db] || k_last;
        if (bad[db] || k_last) begin
          db <= ~db;
          k  <= '0;
        end else begin
          k <= k + SW'(1);
        end
      end else if (s2_load) begin
        s1_valid <= 1'b0;
      end
    end
  end

  // The RAM holds its read data until the next read, so stage one may wait.
  always_ff @(posedge clk) begin
    if (rst) begin
      sig_valid <= 1'b0;
    end else if (s2_load) begin
      sig_valid   <= 1'b1;
      sig_byte    <= (s1_err || !s1_vld) ? 8'd0 : rd_data;
      byte_index  <= s1_idx;
      status      <= s1_err ? dsfp_pkg::STATUS_BAD : dsfp_pkg::STATUS_OK;
      last_of_run <= s1_last;
    end else if (sig_ready) begin
      sig_valid <= 1'b0;
    end
  end

endmodule

// ----- rtl/core/der_signature_to_fixed_pair.sv -----
// Top level of the DER ECDSA signature to fixed R then S converter.
// Depends on dsfp_pkg, dsfp_ram, dsfp_parser and dsfp_drain.
//
// Usage: DER bytes enter on der_byte with der_valid/der_ready, one per item,
// end_of_buffer set on the final byte of a signature. Results leave on
// sig_valid/sig_ready: for a well-formed signature 2*COMPONENT_BYTES items
// (byte_index 0 upward, last_of_run on the final one), otherwise one item
// with status 1, sig_byte 0, byte_index 0 and last_of_run 1.
// Throughput: one input byte per cycle. The store is split into two banks;
// the parser fills one while the other is read out, one result per cycle.
// der_ready drops only when a signature ends while the other bank still
// waits to be read, and rises again once that read-out has issued its last
// entry. After the end-marked byte is accepted, the first result passes the
// RAM read and the output register before it is valid.
// When sig_ready is low the output register holds, the read stage holds,
// and further bytes are still accepted until both banks are busy.
// Reset (synchronous, active high) empties both banks and the output and
// clears the entry valid bits at once, so the store reads as all zero.
module der_signature_to_fixed_pair #(
  parameter int unsigned COMPONENT_BYTES = 32,
  parameter int unsigned MAX_INPUT_BYTES = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       der_valid,
  output logic       der_ready,
  input  logic [7:0] der_byte,
  input  logic       end_of_buffer,
  output logic       sig_valid,
  input  logic       sig_ready,
  output logic [7:0] sig_byte,
  output logic [5:0] byte_index,
  output logic       status,
  output logic       last_of_run
);

  localparam int unsigned STORE = 2 * COMPONENT_BYTES;
  localparam int unsigned SW    = $clog2(STORE);
  localparam int unsigned DEPTH = 2 ** (SW + 1);

  logic                     pb;
  logic [1:0]               full;
  logic [1:0]               full_next;
  logic [1:0]               bad;
  logic [1:0][STORE-1:0]    vbits;
  logic [1:0][STORE-1:0]    vbits_next;
  logic                     take;
  logic [SW-1:0]            wr_slot;
  dsfp_pkg::parse_evt_t     pevt;
  dsfp_pkg::drain_evt_t     devt;
  logic                     rd_en;
  logic                     rd_bank;
  logic [SW-1:0]            rd_slot;
  logic [7:0]               rd_data;
  logic                     entry_valid;

  assign der_ready   = !full[pb];
  assign take        = der_valid && der_ready;
  assign entry_valid = vbits[rd_bank][rd_slot];

  dsfp_parser #(
    .COMPONENT_BYTES (COMPONENT_BYTES),
    .MAX_INPUT_BYTES (MAX_INPUT_BYTES)
  ) u_parser (
    .clk           (clk),
    .rst           (rst),
    .take          (take),
    .der_byte      (der_byte),
    .end_of_buffer (end_of_buffer),
    .wr_slot       (wr_slot),
    .evt           (pevt)
  );

  dsfp_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (pevt.wr_en),
    .wr_addr ({pb, wr_slot}),
    .wr_data (der_byte),
    .rd_en   (rd_en),
    .rd_addr ({rd_bank, rd_slot}),
    .rd_data (rd_data)
  );

  dsfp_drain #(
    .COMPONENT_BYTES (COMPONENT_BYTES)
  ) u_drain (
    .clk         (clk),
    .rst         (rst),
    .full        (full),
    .bad         (bad),
    .rd_en       (rd_en),
    .rd_bank     (rd_bank),
    .rd_slot     (rd_slot),
    .entry_valid (entry_valid),
    .rd_data     (rd_data),
    .evt         (devt),
    .sig_valid   (sig_valid),
    .sig_ready   (sig_ready),
    .sig_byte    (sig_byte),
    .byte_index  (byte_index),
    .status      (status),
    .last_of_run (last_of_run)
  );

  // The drain and the parser never touch the same bank in one cycle.
  always_comb begin
    full_next  = full;
    vbits_next = vbits;
    if (devt.release_bank) begin
      full_next[devt.bank]  = 1'b0;
      vbits_next[devt.bank] = '0;
    end
    if (pevt.wr_en) begin
      vbits_next[pb][wr_slot] = 1'b1;
    end
    if (pevt.sig_done) begin
      full_next[pb] = 1'b1;
    end
  end

  // Bank ownership: the parser fills bank pb, the drain empties the other.
  always_ff @(posedge clk) begin
    if (rst) begin
      pb    <= 1'b0;
      full  <= '0;
      bad   <= '0;
      vbits <= '0;
    end else begin
      full  <= full_next;
      vbits <= vbits_next;
      if (pevt.sig_done) begin
        bad[pb] <= pevt.sig_bad;
        pb      <= ~pb;
      end
    end
  end

  a_no_write_full_bank : assert property (@(posedge clk) disable iff (rst)
    pevt.wr_en |-> !full[pb])
    else $error("byte stored into a bank that still waits for read-out");

  a_release_full_only : assert property (@(posedge clk) disable iff (rst)
    devt.release_bank |-> full[devt.bank])
    else $error("read-out released a bank that was not full");

  a_error_item_alone : assert property (@(posedge clk) disable iff (rst)
    (sig_valid && (status == dsfp_pkg::STATUS_BAD)) |->
      (last_of_run && (byte_index == 6'd0) && (sig_byte == 8'd0)))
    else $error("malformed result is not a single zero item");

  a_handoff_frees_parser : assert property (@(posedge clk) disable iff (rst)
    pevt.sig_done |=> (pb != $past(pb)) && full[$past(pb)])
    else $error("finished signature not handed to the read-out side");

endmodule

// ----- bench/tb_der_signature_to_fixed_pair.sv -----
// Self-checking testbench for der_signature_to_fixed_pair: DER buffers in, R then S bytes out.
// It keeps its own byte-level parser and checks every result item in order.
// Depends on dsfp_pkg and the RTL under rtl/core.
`timescale 1ns / 1ps

module tb_der_signature_to_fixed_pair;

  localparam int unsigned COMP_BYTES  = 32;
  localparam int unsigned MAX_BYTES   = 256;
  localparam int unsigned STORE_BYTES = 2 * COMP_BYTES;
  localparam int unsigned SAT_LIMIT   = MAX_BYTES + 1;
  localparam int unsigned IDLE_PCT    = 28;

  typedef enum logic [3:0] {
    PH_SEEK, PH_SEQLEN, PH_RTAG, PH_RLEN, PH_RLEAD, PH_RBODY,
    PH_STAG, PH_SLEN, PH_SLEAD, PH_SBODY, PH_DONE
  } parse_phase_t;

  typedef struct {
    logic [7:0] data;
    logic [5:0] idx;
    logic       status;
    logic       last;
  } sig_item_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       der_valid = 1'b0;
  logic       der_ready;
  logic [7:0] der_byte = 8'h00;
  logic       end_of_buffer = 1'b0;
  logic       sig_valid;
  logic       sig_ready = 1'b0;
  logic [7:0] sig_byte;
  logic [5:0] byte_index;
  logic       status;
  logic       last_of_run;

  der_signature_to_fixed_pair #(
    .COMPONENT_BYTES(COMP_BYTES),
    .MAX_INPUT_BYTES(MAX_BYTES)
  ) dut (
    .clk(clk), .rst(rst),
    .der_valid(der_valid), .der_ready(der_ready),
    .der_byte(der_byte), .end_of_buffer(end_of_buffer),
    .sig_valid(sig_valid), .sig_ready(sig_ready),
    .sig_byte(sig_byte), .byte_index(byte_index),
    .status(status), .last_of_run(last_of_run)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shared run state.
  bit          quiet = 1'b0;
  int          err_count = 0;
  int          n_buffers = 0;
  int          n_bytes = 0;
  int          n_converted = 0;
  int          n_rejected = 0;
  logic [7:0]  der_buf[$];
  sig_item_t   expected_sig[$];

  // Predicted parser state.
  parse_phase_t pr_phase = PH_SEEK;
  logic [8:0]   pr_total = '0;
  logic [8:0]   pr_aligned = '0;
  logic [7:0]   pr_seq_len = '0;
  logic [7:0]   pr_left = '0;
  logic [6:0]   pr_slot = '0;
  bit           pr_error = 1'b0;
  logic [7:0]   pr_store [STORE_BYTES];

  function automatic void clear_parser();
    pr_phase   = PH_SEEK;
    pr_total   = '0;
    pr_aligned = '0;
    pr_seq_len = '0;
    pr_left    = '0;
    pr_slot    = '0;
    pr_error   = 1'b0;
    foreach (pr_store[k]) pr_store[k] = 8'h00;
  endfunction

  function automatic logic [8:0] sat_inc(input logic [8:0] v);
    return (v < SAT_LIMIT) ? v + 9'd1 : v;
  endfunction

  function automatic void take_length(input logic [7:0] len, input bit half);
    int base;
    base = half ? COMP_BYTES : 0;
    if (len > COMP_BYTES + 1) begin
      pr_error = 1'b1;
    end else if (len == COMP_BYTES + 1) begin
      pr_left  = 8'(COMP_BYTES);
      pr_slot  = 7'(base);
      pr_phase = half ? PH_SLEAD : PH_RLEAD;
    end else if (len == 0) begin
      pr_phase = half ? PH_DONE : PH_STAG;
    end else begin
      pr_left  = len;
      pr_slot  = 7'(base + COMP_BYTES - len);
      pr_phase = half ? PH_SBODY : PH_RBODY;
    end
  endfunction

  function automatic void take_body(input logic [7:0] b, input parse_phase_t after);
    if (pr_slot < STORE_BYTES) pr_store[pr_slot] = b;
    pr_slot = pr_slot + 7'd1;
    if (pr_left > 0) pr_left = pr_left - 8'd1;
    if (pr_left == 0) pr_phase = after;
  endfunction

  // Advances the predicted parser by one accepted byte and queues the
  // results that an end-marked byte produces.
  function automatic void predict_byte(input logic [7:0] b, input logic eob);
    bit        bad;
    sig_item_t it;
    pr_total = sat_inc(pr_total);
    if (pr_phase != PH_SEEK || b == dsfp_pkg::SEQ_TAG) pr_aligned = sat_inc(pr_aligned);
    if (!pr_error) begin
      case (pr_phase)
        PH_SEEK: if (b == dsfp_pkg::SEQ_TAG) pr_phase = PH_SEQLEN;
        PH_SEQLEN: begin
          pr_seq_len = b;
          pr_phase   = PH_RTAG;
        end
        PH_RTAG, PH_STAG: begin
          if (b != dsfp_pkg::INT_TAG) pr_error = 1'b1;
          else pr_phase = (pr_phase == PH_RTAG) ? PH_RLEN : PH_SLEN;
        end
        PH_RLEN: take_length(b, 1'b0);
        PH_SLEN: take_length(b, 1'b1);
        PH_RLEAD, PH_SLEAD: begin
          if (b != dsfp_pkg::LEAD_ZERO) pr_error = 1'b1;
          else pr_phase = (pr_phase == PH_RLEAD) ? PH_RBODY : PH_SBODY;
        end
        PH_RBODY: take_body(b, PH_STAG);
        PH_SBODY: take_body(b, PH_DONE);
        default: ;
      endcase
    end
    if (eob) begin
      bad = pr_error || pr_total < dsfp_pkg::MIN_TOTAL || pr_phase != PH_DONE
          || pr_aligned < dsfp_pkg::MIN_ALIGNED
          || int'(pr_seq_len) + 2 > int'(pr_aligned);
      if (bad) begin
        it.data = 8'h00; it.idx = 6'd0; it.status = dsfp_pkg::STATUS_BAD; it.last = 1'b1;
        expected_sig.push_back(it);
        n_rejected++;
      end else begin
        for (int k = 0; k < STORE_BYTES; k++) begin
          it.data   = pr_store[k];
          it.idx    = k[5:0];
          it.status = dsfp_pkg::STATUS_OK;
          it.last   = (k == STORE_BYTES - 1);
          expected_sig.push_back(it);
        end
        n_converted++;
      end
      clear_parser();
    end
  endfunction

  // Result side: random back-pressure, and an in-order field check.
  always @(negedge clk) begin
    sig_ready = rst ? 1'b0 : (quiet || $urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    sig_item_t want;
    if (!rst && sig_valid && sig_ready) begin
      if (expected_sig.size() == 0) begin
        $error("result with nothing expected: sig_byte %0h byte_index %0d", sig_byte,
               byte_index);
        err_count++;
      end else begin
        want = expected_sig.pop_front();
        if (sig_byte !== want.data) begin
          $error("sig_byte: expected %0h, got %0h", want.data, sig_byte);
          err_count++;
        end
        if (byte_index !== want.idx) begin
          $error("byte_index: expected %0d, got %0d", want.idx, byte_index);
          err_count++;
        end
        if (status !== want.status) begin
          $error("status: expected %0b, got %0b", want.status, status);
          err_count++;
        end
        if (last_of_run !== want.last) begin
          $error("last_of_run: expected %0b, got %0b", want.last, last_of_run);
          err_count++;
        end
      end
    end
  end

  // Sends one byte; the source may idle first, then holds the item until taken.
  task automatic send_item(input logic [7:0] b, input logic eob);
    @(negedge clk);
    while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      der_valid = 1'b0;
      @(negedge clk);
    end
    der_valid     = 1'b1;
    der_byte      = b;
    end_of_buffer = eob;
    @(posedge clk);
    while (!der_ready) @(posedge clk);
    predict_byte(b, eob);
    n_bytes++;
  endtask

  task automatic send_buffer();
    for (int i = 0; i < der_buf.size(); i++) send_item(der_buf[i], i == der_buf.size() - 1);
    n_buffers++;
  endtask

  function automatic logic [7:0] fill_byte(input int fill);
    return (fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill);
  endfunction

  // Bytes that never look like a sequence tag.
  function automatic void add_junk(input int n);
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      b = 8'($urandom_range(0, 255));
      der_buf.push_back((b == dsfp_pkg::SEQ_TAG) ? 8'h31 : b);
    end
  endfunction

  function automatic void add_tail(input int n);
    for (int i = 0; i < n; i++) der_buf.push_back(8'($urandom_range(0, 255)));
  endfunction

  // An INTEGER field; a length of COMP_BYTES+1 gets its leading zero.
  function automatic void add_int(input int len, input int fill);
    der_buf.push_back(dsfp_pkg::INT_TAG);
    der_buf.push_back(8'(len));
    if (len == COMP_BYTES + 1) begin
      der_buf.push_back(dsfp_pkg::LEAD_ZERO);
      for (int i = 0; i < COMP_BYTES; i++) der_buf.push_back(fill_byte(fill));
    end else begin
      for (int i = 0; i < len; i++) der_buf.push_back(fill_byte(fill));
    end
  endfunction

  function automatic void make_sig(input int junk, input int rlen, input int slen,
                                   input int fill);
    der_buf.delete();
    add_junk(junk);
    der_buf.push_back(dsfp_pkg::SEQ_TAG);
    der_buf.push_back(8'(rlen + slen + 4));
    add_int(rlen, fill);
    add_int(slen, fill);
  endfunction

  task automatic test_lengths();
    // Seven bytes are too short; one trailing byte makes the same pair valid.
    make_sig(0, 0, 1, -1);    send_buffer();
    make_sig(0, 0, 1, -1);    add_tail(1); send_buffer();
    // A full-width R with its leading zero and an empty S, sent with no idling.
    quiet = 1'b1;
    make_sig(0, 33, 0, -1);   send_buffer();
    quiet = 1'b0;
  endtask

  task automatic test_malformed();
    der_buf.delete(); add_junk(4); send_buffer();
    // The sequence tag appears too close to the end.
    der_buf.delete();
    for (int i = 0; i < 6; i++) der_buf.push_back(8'h00);
    der_buf.push_back(dsfp_pkg::SEQ_TAG); der_buf.push_back(8'h01); send_buffer();
    make_sig(0, 1, 1, -1); der_buf[1] = 8'hFF; send_buffer();
    make_sig(0, 1, 1, -1); der_buf[2] = 8'h03; send_buffer();
    // An integer length one past the leading-zero form.
    make_sig(0, 1, 1, -1); der_buf[3] = 8'(COMP_BYTES + 2); send_buffer();
    // A length of COMP_BYTES+1 whose leading byte is not zero.
    make_sig(0, 1, 1, -1); der_buf[3] = 8'(COMP_BYTES + 1); der_buf[4] = 8'h80;
    send_buffer();
    // The buffer ends right after the S length, before the S value.
    make_sig(0, 2, 2, -1); der_buf.pop_back(); der_buf.pop_back(); send_buffer();
  endtask

  task automatic test_junk_and_trailing();
    make_sig(2, 1, 2, -1); der_buf[0] = 8'hFF; add_tail(1);
    der_buf.push_back(dsfp_pkg::SEQ_TAG);
    send_buffer();
  endtask

  initial begin
    clear_parser();
    repeat (3) @(posedge clk);
    @(negedge clk) rst = 1'b0;
    test_lengths();
    test_malformed();
    test_junk_and_trailing();
    @(negedge clk) der_valid = 1'b0;
    while (expected_sig.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    $display("Sent %0d DER buffers in %0d bytes: %0d converted, %0d rejected as malformed.",
             n_buffers, n_bytes, n_converted, n_rejected);
    if (err_count == 0) begin
      $display("tb_der_signature_to_fixed_pair: clean");
    end else begin
      $display("tb_der_signature_to_fixed_pair: errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Run stopped at the time limit with %0d results outstanding.",
             expected_sig.size());
    $display("tb_der_signature_to_fixed_pair: errors");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/dsfp_pkg.sv
rtl/core/dsfp_ram.sv
rtl/core/dsfp_parser.sv
rtl/core/dsfp_drain.sv
rtl/core/der_signature_to_fixed_pair.sv
bench/tb_der_signature_to_fixed_pair.sv
